// ----- src/ppbtb_pkg.sv -----
// Shared constants, types and codes of the perceptron branch predictor.
package ppbtb_pkg;

    // Geometry (TABLE_ENTRIES is a power of two: the index is the low address bits)
    localparam int TABLE_ENTRIES = 1024;
    localparam int HISTORY_LEN   = 10;
    localparam int WEIGHT_BITS   = 8;
    localparam int PC_BITS       = 48;
    localparam int THR_BITS      = 10;

    localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
    localparam int TAG_BITS  = PC_BITS - IDX_BITS;
    localparam int SUM_BITS  = WEIGHT_BITS + $clog2(HISTORY_LEN) + 1;
    localparam int CMP_BITS  = (SUM_BITS > THR_BITS) ? SUM_BITS : THR_BITS;
    localparam int TREE_LVLS = $clog2(HISTORY_LEN);
    localparam int TREE_SIZE = 1 << TREE_LVLS;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(33);

    // History term codes: +1, -1 and 0 in two's complement
    localparam logic [1:0] HIST_POS  = 2'b01;
    localparam logic [1:0] HIST_NEG  = 2'b11;
    localparam logic [1:0] HIST_ZERO = 2'b00;

    localparam logic [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
    localparam logic [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
    localparam logic [WEIGHT_BITS-1:0] W_ONE = WEIGHT_BITS'(1);

    typedef logic [HISTORY_LEN-1:0][1:0] hist_vec_t;

    typedef struct packed {
        logic                                    valid;
        logic [TAG_BITS-1:0]                     tag;
        logic [HISTORY_LEN-1:0][WEIGHT_BITS-1:0] weights;
    } row_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        row_t                row;
    } wr_req_t;

    typedef struct packed {
        logic hit;
        logic predicted_taken;
        logic correct;
        logic replaced;
    } res_t;

endpackage

// ----- src/ppbtb_ifs.sv -----
// Channel interfaces: resolved-branch input and prediction result output.
interface ppbtb_branch_if;
    import ppbtb_pkg::*;

    logic               valid;
    logic               ready;
    logic [PC_BITS-1:0] branch_pc;
    logic               taken;

    modport source (output valid, output branch_pc, output taken, input ready);
    modport sink   (input valid, input branch_pc, input taken, output ready);
endinterface

interface ppbtb_result_if;
    logic valid;
    logic ready;
    logic hit;
    logic predicted_taken;
    logic correct;
    logic replaced;

    modport source (output valid, output hit, output predicted_taken, output correct,
                    output replaced, input ready);
    modport sink   (input valid, input hit, input predicted_taken, input correct,
                    input replaced, output ready);
endinterface

// ----- src/perceptron_branch_predictor_btb.sv -----
// Top level of the perceptron branch predictor with direct-mapped branch table.
//
// Channels: "branch" takes one resolved branch per beat (branch_pc, taken);
// "result" returns one beat per branch (hit, predicted_taken, correct,
// replaced) in input order. A beat moves when valid and ready are both high.
// cfg_we/cfg_wdata write train_threshold; write it only while the block is idle.
//
// Timing: the accepting edge registers the branch and the table read together;
// predict/train is then loaded into the result register, or the skid entry,
// once the output has room. Throughput: one branch per cycle while the output
// has room, set by the single read-modify-write pass over the table
// row; a same-row update that is still being written is bypassed into the
// next lookup.
//
// Reset: the history returns to its reset pattern, the threshold to 33, and a
// clearing sweep zeroes the 1024 table rows, one row per cycle; branch.ready
// stays low until that sweep has ended after reset is released.
//
// Stall: when result.ready is low, one further result is held in a skid
// entry; after that the lookup stage holds and branch.ready drops.
module perceptron_branch_predictor_btb (
    input  logic                           clk,
    input  logic                           rst_n,
    ppbtb_branch_if.sink                   branch,
    ppbtb_result_if.source                 result,
    input  logic                           cfg_we,
    input  logic [ppbtb_pkg::THR_BITS-1:0] cfg_wdata
);
    import ppbtb_pkg::*;

    logic [THR_BITS-1:0] thr_reg;
    logic                clearing;
    logic                re;
    logic [IDX_BITS-1:0] raddr;
    row_t                row;
    wr_req_t             wr;
    logic                room;
    logic                push;
    res_t                res;

    // Hold the training threshold; update on every write beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    // Table rows: valid, upper address tag, weights
    ppbtb_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .re       (re),
        .raddr    (raddr),
        .wr       (wr),
        .rdata    (row),
        .clearing (clearing)
    );

    // Lookup, predict, train, advance history
    ppbtb_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (branch.valid),
        .in_ready (branch.ready),
        .in_pc    (branch.branch_pc),
        .in_taken (branch.taken),
        .thr      (thr_reg),
        .clearing (clearing),
        .re       (re),
        .raddr    (raddr),
        .row      (row),
        .wr       (wr),
        .out_room (room),
        .push     (push),
        .res      (res)
    );

    // Result register plus skid entry
    ppbtb_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .data   (res),
        .room   (room),
        .result (result)
    );

endmodule

// ----- src/ppbtb_table.sv -----
// Branch table memory with post-reset clearing sweep and write-to-read bypass.
module ppbtb_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          re,
    input  logic [ppbtb_pkg::IDX_BITS-1:0] raddr,
    input  ppbtb_pkg::wr_req_t            wr,
    output ppbtb_pkg::row_t               rdata,
    output logic                          clearing
);
    import ppbtb_pkg::*;

    row_t                mem [TABLE_ENTRIES];
    row_t                mem_q_reg;
    row_t                byp_row_reg;
    logic                byp_valid_reg;
    logic                clearing_reg;
    logic [IDX_BITS-1:0] clr_idx_reg;

    logic                w_en;
    logic [IDX_BITS-1:0] w_addr;
    row_t                w_row;

    assign w_en     = clearing_reg || wr.en;
    assign w_addr   = clearing_reg ? clr_idx_reg : wr.addr;
    assign w_row    = clearing_reg ? '0 : wr.row;
    assign clearing = clearing_reg;
    assign rdata    = byp_valid_reg ? byp_row_reg : mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (w_en)
        begin
            mem[w_addr] <= w_row;
        end
        if (re)
        begin
            mem_q_reg   <= mem[raddr];
            byp_row_reg <= w_row;
        end
    end

    // Take the row being written when it targets the row being read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (re)
        begin
            byp_valid_reg <= w_en && (w_addr == raddr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_idx_reg <= clr_idx_reg + IDX_BITS'(1);
            if (clr_idx_reg == IDX_BITS'(TABLE_ENTRIES - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    a_no_read_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !re)
        else $error("table read during clearing sweep");

endmodule

// ----- src/ppbtb_core.sv -----
// Lookup stage and predict/train logic with global history register.
module ppbtb_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ppbtb_pkg::PC_BITS-1:0]  in_pc,
    input  logic                           in_taken,
    input  logic [ppbtb_pkg::THR_BITS-1:0] thr,
    input  logic                           clearing,
    output logic                           re,
    output logic [ppbtb_pkg::IDX_BITS-1:0] raddr,
    input  ppbtb_pkg::row_t                row,
    output ppbtb_pkg::wr_req_t             wr,
    input  logic                           out_room,
    output logic                           push,
    output ppbtb_pkg::res_t                res
);
    import ppbtb_pkg::*;

    logic                s1_valid_reg;
    logic [PC_BITS-1:0]  s1_pc_reg;
    logic                s1_taken_reg;
    hist_vec_t           history_reg;
    hist_vec_t           history_next;

    logic                fire;
    logic                hit;
    logic                pred;
    logic                train;
    logic [TAG_BITS-1:0] tag;
    logic signed [SUM_BITS-1:0] acc [TREE_SIZE];
    logic signed [SUM_BITS-1:0] sum;
    logic [SUM_BITS-1:0] mag;
    logic [HISTORY_LEN-1:0][WEIGHT_BITS-1:0] trained;

    function automatic logic [WEIGHT_BITS-1:0] sat_step(
        input logic [WEIGHT_BITS-1:0] w,
        input logic [1:0]             h,
        input logic                   tk
    );
        logic up;
        logic dn;
        up = ((h == HIST_POS) && tk) || ((h == HIST_NEG) && !tk);
        dn = ((h == HIST_POS) && !tk) || ((h == HIST_NEG) && tk);
        if (up && (w != W_MAX))
            return w + W_ONE;
        else if (dn && (w != W_MIN))
            return w - W_ONE;
        else
            return w;
    endfunction

    assign fire     = s1_valid_reg && out_room;
    assign in_ready = !clearing && (!s1_valid_reg || fire);
    assign re       = in_valid && in_ready;
    assign raddr    = in_pc[IDX_BITS-1:0];
    assign tag      = s1_pc_reg[PC_BITS-1:IDX_BITS];
    assign hit      = row.valid && (row.tag == tag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            s1_pc_reg    <= in_pc;
            s1_taken_reg <= in_taken;
        end
    end

    // Dot product as a balanced adder tree
    always_comb
    begin
        for (int i = 0; i < TREE_SIZE; i++)
        begin
            acc[i] = '0;
        end
        for (int i = 0; i < HISTORY_LEN; i++)
        begin
            case (history_reg[i])
                HIST_POS: acc[i] = SUM_BITS'($signed(row.weights[i]));
                HIST_NEG: acc[i] = -SUM_BITS'($signed(row.weights[i]));
                default:  acc[i] = '0;
            endcase
        end
        for (int lvl = 0; lvl < TREE_LVLS; lvl++)
        begin
            for (int i = 0; i < (TREE_SIZE >> (lvl + 1)); i++)
            begin
                acc[i] = acc[2*i] + acc[2*i+1];
            end
        end
        sum = acc[0];
    end

    assign mag   = (sum < 0) ? SUM_BITS'(-sum) : SUM_BITS'(sum);
    assign pred  = hit && (sum > 0);
    assign train = (pred != s1_taken_reg) || (CMP_BITS'(mag) <= CMP_BITS'(thr));

    always_comb
    begin
        for (int i = 0; i < HISTORY_LEN; i++)
        begin
            trained[i] = sat_step(row.weights[i], history_reg[i], s1_taken_reg);
        end
        history_next = history_reg;
        for (int i = HISTORY_LEN - 1; i > 0; i--)
        begin
            history_next[i] = history_reg[i-1];
        end
        history_next[0] = s1_taken_reg ? HIST_POS : HIST_NEG;
    end

    // Reset pattern: newest term +1, all older terms zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            history_reg <= hist_vec_t'(HIST_POS);
        end
        else if (fire && hit)
        begin
            history_reg <= history_next;
        end
    end

    // Write back on a hit (training) or insert on a taken miss
    always_comb
    begin
        wr.en          = fire && (hit || s1_taken_reg);
        wr.addr        = s1_pc_reg[IDX_BITS-1:0];
        wr.row.valid   = 1'b1;
        wr.row.tag     = tag;
        wr.row.weights = (hit && train) ? trained : row.weights;
    end

    assign push                = fire;
    assign res.hit             = hit;
    assign res.predicted_taken = pred;
    assign res.correct         = (pred == s1_taken_reg);
    assign res.replaced        = !hit && s1_taken_reg && row.valid;

    a_miss_keeps_history: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !hit) |=> $stable(history_reg))
        else $error("history changed on a miss");

    a_write_only_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (s1_valid_reg && out_room && !clearing))
        else $error("table write without a completing item");

endmodule

// ----- src/ppbtb_outbuf.sv -----
// Result register with one skid entry toward the output channel.
module ppbtb_outbuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ppbtb_pkg::res_t data,
    output logic            room,
    ppbtb_result_if.source  result
);
    import ppbtb_pkg::*;

    logic main_valid_reg;
    logic skid_valid_reg;
    res_t main_reg;
    res_t skid_reg;
    logic main_free;

    assign main_free = !main_valid_reg || result.ready;
    assign room      = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : data;
        end
        else if (push)
        begin
            skid_reg <= data;
        end
    end

    assign result.valid           = main_valid_reg;
    assign result.hit             = main_reg.hit;
    assign result.predicted_taken = main_reg.predicted_taken;
    assign result.correct         = main_reg.correct;
    assign result.replaced        = main_reg.replaced;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry held with empty result register");

endmodule
